// File: src/multichannel_pulse_counter_assert.svh
// Assertion macros used by the pulse counter top level.
`ifndef MULTICHANNEL_PULSE_COUNTER_ASSERT_SVH
`define MULTICHANNEL_PULSE_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition that must never be seen outside reset.
`define MPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/mpc_pkg.sv
// Shared types and constants of the multichannel pulse counter.
package mpc_pkg;

  localparam int CHANNEL_COUNT_DEF = 9;
  localparam int PIN_BITS          = 9;
  localparam int IDX_W             = 4;
  localparam int CNT_W             = 16;
  localparam int RUN_W             = 8;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int IN_DATA_W         = 24;
  localparam int OUT_DATA_W        = 40;

  localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_HIGH_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_LOW_THRESHOLD   = 2'd2;

  localparam logic [7:0] RST_SAMPLE_INTERVAL = 8'd10;
  localparam logic [7:0] RST_HIGH_THRESHOLD  = 8'd3;
  localparam logic [7:0] RST_LOW_THRESHOLD   = 8'd3;

  typedef struct packed {
    logic [7:0] sample_interval;
    logic [7:0] high_threshold;
    logic [7:0] low_threshold;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0] channel_index;
    logic [CNT_W-1:0] low_pulse_count;
    logic [CNT_W-1:0] high_pulse_count;
    logic             low_wrapped;
    logic             high_wrapped;
    logic             count_changed;
    logic             last_channel;
  } result_t;

endpackage

// File: src/multichannel_pulse_counter.sv
// Top level of the multichannel debounced pulse counter.
//
//   channel  direction  handshake             payload
//   in_      slave      in_tvalid/in_tready   tdata: ticks_elapsed, pin_levels
//   out_     master     out_tvalid/out_tready tdata: counts and flags, tuser, tlast
//   cfg_     write      cfg_we                cfg_index, cfg_wdata
//
// An input transaction that does not sample the pins yields nothing.
// A sampling gives CHANNEL_COUNT results, one per cycle while the output is not stalled,
// set by the back end's channel sequencer that updates one channel's state per cycle.
// Input is taken each cycle while the two-entry sampling queue has room.
// A stalled output holds its result and stops the channel walk; reset is synchronous.
module multichannel_pulse_counter #(
  parameter int CHANNEL_COUNT = mpc_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] ticks_elapsed, [16:8] pin_levels, [23:17] zero
  input  logic [mpc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [3:0] channel_index, [19:4] low_pulse_count, [35:20] high_pulse_count,
  // [36] low_wrapped, [37] high_wrapped, [39:38] zero
  output logic [mpc_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] count_changed
  output logic [0:0]                     out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import mpc_pkg::*;

`include "multichannel_pulse_counter_assert.svh"

  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [CH_W+IDX_W-1:0] LAST_EXT = (CH_W + IDX_W)'(CHANNEL_COUNT - 1);

  cfg_t                cfg_r;
  queue_stat_t         q_stat;
  logic                push;
  logic                pop;
  logic [PIN_BITS-1:0] push_pins;
  logic [PIN_BITS-1:0] head_pins;
  result_t             res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_interval <= RST_SAMPLE_INTERVAL;
      cfg_r.high_threshold  <= RST_HIGH_THRESHOLD;
      cfg_r.low_threshold   <= RST_LOW_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_INTERVAL: cfg_r.sample_interval <= cfg_wdata;
        CFG_HIGH_THRESHOLD:  cfg_r.high_threshold  <= cfg_wdata;
        CFG_LOW_THRESHOLD:   cfg_r.low_threshold   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mpc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .ticks_elapsed (in_tdata[7:0]),
    .pin_levels    (in_tdata[PIN_BITS+7:8]),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_pins     (push_pins)
  );

  mpc_queue #(
    .WIDTH (PIN_BITS),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_pins),
    .pop       (pop),
    .head_data (head_pins),
    .stat      (q_stat)
  );

  mpc_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .head_pins (head_pins),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // output packing
  assign out_tdata = {2'b00, res.high_wrapped, res.low_wrapped, res.high_pulse_count,
                      res.low_pulse_count, res.channel_index};
  assign out_tuser = res.count_changed;
  assign out_tlast = res.last_channel;

  `MPC_ASSERT_IMP(a_last_index, out_tvalid && out_tlast, out_tdata[3:0] == LAST_EXT[IDX_W-1:0], "last result not on final channel")
  `MPC_ASSERT_NEVER(a_queue_stat, q_stat.full && q_stat.empty, "queue both full and empty")
  `MPC_ASSERT_IMP(a_push_room, push, !q_stat.full, "sampling pushed into full queue")
  `MPC_ASSERT_IMP(a_pop_data, pop, !q_stat.empty, "sampling popped from empty queue")

endmodule

// File: src/mpc_front.sv
// Front end: tick postscaler that decides which input transactions sample the pins.
module mpc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   ticks_elapsed,
  input  logic [mpc_pkg::PIN_BITS-1:0] pin_levels,
  input  mpc_pkg::cfg_t                cfg,
  input  mpc_pkg::queue_stat_t         q_stat,
  output logic                         push,
  output logic [mpc_pkg::PIN_BITS-1:0] push_pins
);
  import mpc_pkg::*;

  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  logic [7:0] acc_sum;
  logic       accept;
  logic       hit;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign acc_sum   = acc_r + ticks_elapsed;
  assign hit       = acc_sum >= cfg.sample_interval;
  assign push      = accept && hit;
  assign push_pins = pin_levels;

  // accumulate wrapped ticks, drop one interval on each sampling
  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = hit ? (acc_sum - cfg.sample_interval) : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: src/mpc_queue.sv
// Small register queue of pending samplings between front and back end.
module mpc_queue #(
  parameter int WIDTH = mpc_pkg::PIN_BITS,
  parameter int DEPTH = mpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     head_data,
  output mpc_pkg::queue_stat_t stat
);
  import mpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == CNT_FULL;
  assign stat.empty = cnt_r == '0;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/mpc_back.sv
// Back end: walks the channels of one sampling, updates runs and counts, drives results.
module mpc_back #(
  parameter int CHANNEL_COUNT = mpc_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpc_pkg::cfg_t                cfg,
  input  mpc_pkg::queue_stat_t         q_stat,
  input  logic [mpc_pkg::PIN_BITS-1:0] head_pins,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mpc_pkg::result_t             out_res
);
  import mpc_pkg::*;

  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNEL_COUNT - 1);

  logic [RUN_W-1:0] hrun_r [CHANNEL_COUNT];
  logic [RUN_W-1:0] lrun_r [CHANNEL_COUNT];
  logic [CNT_W-1:0] hcnt_r [CHANNEL_COUNT];
  logic [CNT_W-1:0] lcnt_r [CHANNEL_COUNT];
  logic             hwrap_r [CHANNEL_COUNT];
  logic             lwrap_r [CHANNEL_COUNT];

  logic                busy_r;
  logic [CH_W-1:0]     ch_r;
  logic [PIN_BITS-1:0] pins_r;
  logic                out_valid_r;
  result_t             out_res_r;

  logic [CHANNEL_COUNT-1:0] lvl_vec;
  logic                     level;
  logic                     advance;
  logic                     load;
  logic                     last;
  logic [CH_W+IDX_W-1:0]    ch_ext;

  logic [RUN_W-1:0] run_cur, run_inc;
  logic [CNT_W-1:0] cnt_cur, cnt_inc;
  logic [RUN_W-1:0] thr;
  logic             run_grow, hit;
  logic [RUN_W-1:0] hrun_nxt, lrun_nxt;
  logic [CNT_W-1:0] hcnt_nxt, lcnt_nxt;
  logic             hwrap_nxt, lwrap_nxt;

  // lines without a pin bit sample low
  for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_lvl
    if (i < PIN_BITS) begin : g_pin
      assign lvl_vec[i] = pins_r[i];
    end else begin : g_nopin
      assign lvl_vec[i] = 1'b0;
    end
  end

  assign level   = lvl_vec[ch_r];
  assign last    = ch_r == CH_LAST;
  assign advance = busy_r && (!out_valid_r || out_ready);
  assign load    = !q_stat.empty && (!busy_r || (advance && last));
  assign pop     = load;
  assign ch_ext  = {{IDX_W{1'b0}}, ch_r};

  // run and count update of the selected channel
  always_comb begin
    run_cur  = level ? hrun_r[ch_r] : lrun_r[ch_r];
    cnt_cur  = level ? hcnt_r[ch_r] : lcnt_r[ch_r];
    thr      = level ? cfg.high_threshold : cfg.low_threshold;
    run_grow = run_cur != RUN_MAX;
    run_inc  = run_cur + 1'b1;
    cnt_inc  = cnt_cur + 1'b1;
    hit      = run_grow && (run_inc == thr);

    hrun_nxt  = hrun_r[ch_r];
    lrun_nxt  = lrun_r[ch_r];
    hcnt_nxt  = hcnt_r[ch_r];
    lcnt_nxt  = lcnt_r[ch_r];
    hwrap_nxt = hwrap_r[ch_r];
    lwrap_nxt = lwrap_r[ch_r];
    if (level) begin
      lrun_nxt = '0;
      if (run_grow) hrun_nxt = run_inc;
      if (hit) begin
        hcnt_nxt = cnt_inc;
        if (cnt_inc == '0) hwrap_nxt = 1'b1;
      end
    end else begin
      hrun_nxt = '0;
      if (run_grow) lrun_nxt = run_inc;
      if (hit) begin
        lcnt_nxt = cnt_inc;
        if (cnt_inc == '0) lwrap_nxt = 1'b1;
      end
    end
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        hrun_r[i]  <= RUN_MAX;
        lrun_r[i]  <= RUN_MAX;
        hcnt_r[i]  <= '0;
        lcnt_r[i]  <= '0;
        hwrap_r[i] <= 1'b0;
        lwrap_r[i] <= 1'b0;
      end
    end else if (advance) begin
      hrun_r[ch_r]  <= hrun_nxt;
      lrun_r[ch_r]  <= lrun_nxt;
      hcnt_r[ch_r]  <= hcnt_nxt;
      lcnt_r[ch_r]  <= lcnt_nxt;
      hwrap_r[ch_r] <= hwrap_nxt;
      lwrap_r[ch_r] <= lwrap_nxt;
    end
  end

  // channel sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        ch_r   <= '0;
      end else if (advance) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          ch_r <= ch_r + 1'b1;
        end
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      pins_r <= head_pins;
    end
    if (advance) begin
      out_res_r.channel_index    <= ch_ext[IDX_W-1:0];
      out_res_r.low_pulse_count  <= lcnt_nxt;
      out_res_r.high_pulse_count <= hcnt_nxt;
      out_res_r.low_wrapped      <= lwrap_nxt;
      out_res_r.high_wrapped     <= hwrap_nxt;
      out_res_r.count_changed    <= hit;
      out_res_r.last_channel     <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
